[src/rqt_pkg.sv]
// ----------------------------------------------------------------------------
// Read quality trimmer package
// Beat types, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package rqt_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned THR_W   = 7;
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned CNT_W   = 48;
    localparam int unsigned GOOD_W  = 32;
    localparam int unsigned SCORE_W = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam int unsigned MAX_READ_LENGTH_DEF = 4096;

    localparam logic [THR_W-1:0] SCORE_OFFSET_RST   = 7'd33;
    localparam logic [THR_W-1:0] TRIM_THRESHOLD_RST = 7'd20;
    localparam logic [THR_W-1:0] HIGH_QUAL_THR_RST  = 7'd30;
    localparam logic [LEN_W-1:0] MIN_GOOD_LEN_RST   = 13'd34;

    localparam logic signed [SCORE_W-1:0] ERROR_SCORE_LIMIT = -9'sd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_OFFSET   = 2'd0,
        CFG_TRIM_THRESHOLD = 2'd1,
        CFG_HIGH_QUAL_THR  = 2'd2,
        CFG_MIN_GOOD_LEN   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [CHAR_W-1:0] quality_char;
        logic              end_of_read;
    } t_in_beat;

    typedef struct packed {
        logic [LEN_W-1:0]        trim_length;
        logic                    good_read;
        logic                    format_error;
        logic [CNT_W-1:0]        bases_total;
        logic signed [CNT_W-1:0] score_sum;
        logic [CNT_W-1:0]        high_bases_total;
        logic [GOOD_W-1:0]       good_reads_total;
    } t_out_beat;

endpackage

[src/read_quality_trimmer_top.sv]
// ----------------------------------------------------------------------------
// Read quality trimmer
// Takes one quality character per cycle, back to back, and gives one result
// beat at the end of each read: the trim length (index of the first score
// below the trim threshold, else the read length), the good flag and
// saturating running totals. A character enters an input register and is
// scored, counted and trimmed in one pass into the result register, from
// which the beat is offered. Input is stalled only while a result-bearing
// character waits behind a result that has not been taken. A score
// below -5 gives one result with format_error set and halts the block;
// later beats are accepted and dropped until reset.
// ----------------------------------------------------------------------------
module read_quality_trimmer_top
    import rqt_pkg::*;
#(
    parameter int unsigned MAX_READ_LENGTH = MAX_READ_LENGTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned POS_W = $clog2(MAX_READ_LENGTH + 1);
    localparam int unsigned CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_READ_LENGTH);

    logic [THR_W-1:0] r_score_offset;
    logic [THR_W-1:0] r_trim_thr;
    logic [THR_W-1:0] r_high_thr;
    logic [LEN_W-1:0] r_min_good;

    logic              r_in_vld;
    t_in_beat          r_in;
    logic              r_out_vld;
    t_out_beat         r_out;

    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_cut_found, n_cut_found;
    logic [POS_W-1:0]        r_cut_pos, n_cut_pos;
    logic [CNT_W-1:0]        r_bases, n_bases;
    logic signed [CNT_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]        r_high, n_high;
    logic [GOOD_W-1:0]       r_good_cnt, n_good_cnt;
    logic                    r_halted;

    logic signed [SCORE_W-1:0] score;
    logic signed [CNT_W:0]     sum_wide;
    logic                      fmt_err;
    logic                      has_result;
    logic                      advance;
    logic                      hit;
    logic [POS_W-1:0]          pos_inc;
    logic [POS_W-1:0]          trim;
    logic                      good;
    t_out_beat                 n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_offset <= SCORE_OFFSET_RST;
            r_trim_thr     <= TRIM_THRESHOLD_RST;
            r_high_thr     <= HIGH_QUAL_THR_RST;
            r_min_good     <= MIN_GOOD_LEN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SCORE_OFFSET:   r_score_offset <= i_cfg_data[THR_W-1:0];
                CFG_TRIM_THRESHOLD: r_trim_thr     <= i_cfg_data[THR_W-1:0];
                CFG_HIGH_QUAL_THR:  r_high_thr     <= i_cfg_data[THR_W-1:0];
                CFG_MIN_GOOD_LEN:   r_min_good     <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        score    = $signed({1'b0, r_in.quality_char}) - $signed({2'b00, r_score_offset});
        fmt_err  = !r_halted && (score < ERROR_SCORE_LIMIT);

        n_bases  = (r_bases != {CNT_W{1'b1}}) ? r_bases + 1'b1 : r_bases;
        sum_wide = {r_sum[CNT_W-1], r_sum} + (CNT_W+1)'(score);
        if (sum_wide[CNT_W] != sum_wide[CNT_W-1]) begin
            n_sum = sum_wide[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
        end else begin
            n_sum = sum_wide[CNT_W-1:0];
        end
        n_high = r_high;
        if (score > $signed({2'b00, r_high_thr}) && r_high != {CNT_W{1'b1}}) begin
            n_high = r_high + 1'b1;
        end

        hit         = !r_cut_found && (score < $signed({2'b00, r_trim_thr}));
        n_cut_found = r_cut_found || hit;
        n_cut_pos   = hit ? r_pos : r_cut_pos;
        pos_inc     = (r_pos < POS_MAX) ? r_pos + 1'b1 : r_pos;
        n_pos       = pos_inc;
        trim        = n_cut_found ? n_cut_pos : pos_inc;
        good        = CMP_W'(trim) >= CMP_W'(r_min_good);
        n_good_cnt  = r_good_cnt;
        if (good && r_good_cnt != {GOOD_W{1'b1}}) begin
            n_good_cnt = r_good_cnt + 1'b1;
        end
        if (r_in.end_of_read) begin
            n_pos       = '0;
            n_cut_found = 1'b0;
            n_cut_pos   = '0;
        end

        if (fmt_err) begin
            n_out.trim_length      = '0;
            n_out.good_read        = 1'b0;
            n_out.format_error     = 1'b1;
            n_out.bases_total      = r_bases;
            n_out.score_sum        = r_sum;
            n_out.high_bases_total = r_high;
            n_out.good_reads_total = r_good_cnt;
        end else begin
            n_out.trim_length      = LEN_W'(trim);
            n_out.good_read        = good;
            n_out.format_error     = 1'b0;
            n_out.bases_total      = n_bases;
            n_out.score_sum        = n_sum;
            n_out.high_bases_total = n_high;
            n_out.good_reads_total = n_good_cnt;
        end

        has_result = r_in_vld && !r_halted && (fmt_err || r_in.end_of_read);
        advance    = r_in_vld && (!has_result || !r_out_vld || i_out_ready);
    end

    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // advance the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && has_result) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_cut_found <= 1'b0;
            r_cut_pos   <= '0;
            r_bases     <= '0;
            r_sum       <= '0;
            r_high      <= '0;
            r_good_cnt  <= '0;
            r_halted    <= 1'b0;
        end else if (advance && !r_halted) begin
            if (fmt_err) begin
                r_halted <= 1'b1;
            end else begin
                r_pos       <= n_pos;
                r_cut_found <= n_cut_found;
                r_cut_pos   <= n_cut_pos;
                r_bases     <= n_bases;
                r_sum       <= n_sum;
                r_high      <= n_high;
                if (r_in.end_of_read) begin
                    r_good_cnt <= n_good_cnt;
                end
            end
        end
    end

endmodule
